>>> hw/rtl/first_byte_bucketed_key_index_unit_defines.svh
// Assertion macros for the bucketed key index.
// Used by the checker module; needs no other file.
`ifndef FIRST_BYTE_BUCKETED_KEY_INDEX_UNIT_DEFINES_SVH
`define FIRST_BYTE_BUCKETED_KEY_INDEX_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define FBK_ASSERT_IMPL(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define FBK_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> hw/rtl/fbki_pkg.sv
// Shared types and constants for the bucketed key index.
// No dependencies.
`timescale 1ns / 1ps
package fbki_pkg;
    localparam int BUCKET_DEPTH_DEF = 16;
    localparam int BUCKET_COUNT_DEF = 256;
    localparam int CNT_W = 13;
    localparam logic [CNT_W-1:0] MAX_ITEMS_RST = 13'd4096;
    localparam logic [CNT_W-1:0] CNT_SAT = 13'h1FFF;
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_INDEX_FULL = 2'd1;
    localparam logic [1:0] ST_BUCKET_FULL = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;
    localparam int IN_W = 2 + 64 + 64 + 32 + 40 + 32;   // 234
    localparam int IN_BYTES_W = 240;
    localparam int OUT_W = 2 + 1 + 40 + 32;             // 75
    localparam int OUT_BYTES_W = 80;
    typedef struct packed {
        logic [31:0] size;
        logic [39:0] offset;
        logic [31:0] key_low;
        logic [63:0] key_mid;
        logic [63:0] key_high;
    } entry_t;
endpackage

>>> hw/rtl/first_byte_bucketed_key_index_unit.sv
// Top level of the bucketed key index: fill table, entry memory, scan sequencer.
// Depends on fbki_pkg.
`timescale 1ns / 1ps
// Channel  Dir  Handshake                Payload
// s_       in   s_tvalid / s_tready      s_tdata: request word
// m_       out  m_tvalid / m_tready      m_tdata: result word
// cfg_     in   cfg_valid / cfg_ready    cfg_data: max_items
//
// Flow: inserts, and lookups/updates on an empty bucket, are answered from the
// decode state. Lookup and update then scan the bucket slot by slot (read,
// then compare), up to the bucket's fill on a miss; an update hit adds a
// write-back state. The slots are scanned in turn since there is one read port.
// One word at a time; the next request is taken only after the result word
// has left the output register.
// Reset: synchronous, active low; clears item total and control, then a
// pass over all buckets zeroes the fill table with s_tready low.
// Entry memory is not cleared: slots are read only below the fill.
module first_byte_bucketed_key_index_unit #(
    parameter int BUCKET_DEPTH = fbki_pkg::BUCKET_DEPTH_DEF,
    parameter int BUCKET_COUNT = fbki_pkg::BUCKET_COUNT_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // [1:0] operation, [65:2] key_high, [129:66] key_mid, [161:130] key_low,
    // [201:162] data_offset_in, [233:202] data_size_in, rest zero
    input  logic [fbki_pkg::IN_BYTES_W-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // [1:0] status, [2] found, [42:3] data_offset_out, [74:43] data_size_out
    output logic [fbki_pkg::OUT_BYTES_W-1:0] m_tdata,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [fbki_pkg::CNT_W-1:0] cfg_data
);
    localparam int BK_W = $clog2(BUCKET_COUNT);
    localparam int SL_W = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int FL_W = $clog2(BUCKET_DEPTH + 1);
    localparam int AD_W = BK_W + SL_W;
    localparam int DEPTH = BUCKET_COUNT * (1 << SL_W);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;

    fbki_pkg::entry_t mem [DEPTH];
    fbki_pkg::entry_t rd_reg;
    logic [FL_W-1:0] fill_mem [BUCKET_COUNT];
    logic [fbki_pkg::CNT_W-1:0] max_reg, total_reg;
    logic [2:0] st_reg;
    logic [1:0] op_reg;
    fbki_pkg::entry_t req_reg;
    logic [BK_W-1:0] bk_reg;
    logic [FL_W-1:0] n_reg;      // fill of the bucket
    logic [FL_W-1:0] idx_reg;    // slot being read
    logic [SL_W-1:0] hit_reg;
    logic [fbki_pkg::OUT_W-1:0] out_reg;
    logic ov_reg;
    logic clr_reg;               // fill table clearing pass after reset
    logic [BK_W-1:0] clr_idx_reg;

    logic [1:0] in_op;
    fbki_pkg::entry_t in_e;
    assign in_op = s_tdata[1:0];
    assign in_e = {s_tdata[233:202], s_tdata[201:162], s_tdata[161:130],
                   s_tdata[129:66], s_tdata[65:2]};

    assign s_tready = (st_reg == S_IDLE) && !ov_reg && !clr_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid = ov_reg;
    assign m_tdata = {{(fbki_pkg::OUT_BYTES_W - fbki_pkg::OUT_W){1'b0}}, out_reg};

    logic key_eq;
    assign key_eq = rd_reg.key_high == req_reg.key_high &&
                    rd_reg.key_mid == req_reg.key_mid &&
                    rd_reg.key_low == req_reg.key_low;

    // insert that lands in the bucket
    logic ins_ok;
    assign ins_ok = st_reg == S_DEC && op_reg == fbki_pkg::OP_INSERT
                    && total_reg < max_reg && n_reg < FL_W'(BUCKET_DEPTH);

    // memory read/write; one port each
    logic we;
    logic [AD_W-1:0] wa, ra;
    fbki_pkg::entry_t wd;
    always_comb begin
        we = 1'b0;
        wa = {bk_reg, hit_reg};
        wd = req_reg;
        if (ins_ok) begin
            we = 1'b1;
            wa = {bk_reg, n_reg[SL_W-1:0]};
        end else if (st_reg == S_WB) begin
            // keys equal the request on a hit
            we = 1'b1;
        end
        ra = {bk_reg, idx_reg[SL_W-1:0]};
    end
    always_ff @(posedge aclk) begin
        if (we) mem[wa] <= wd;
        rd_reg <= mem[ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
            total_reg <= '0;
            max_reg <= fbki_pkg::MAX_ITEMS_RST;
            clr_reg <= 1'b1;
            clr_idx_reg <= '0;
        end else begin
            if (clr_reg) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == BK_W'(BUCKET_COUNT - 1)) clr_reg <= 1'b0;
            end
            if (cfg_valid) max_reg <= cfg_data;
            if (ov_reg && m_tready) ov_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        op_reg <= in_op;
                        req_reg <= in_e;
                        bk_reg <= in_e.key_high[63 -: BK_W];
                        idx_reg <= '0;
                        st_reg <= S_DEC;
                    end
                end
                S_DEC: begin
                    // n_reg valid here (loaded below on accept)
                    if (op_reg == fbki_pkg::OP_INSERT) begin
                        if (total_reg >= max_reg)
                            out_reg <= {73'd0, fbki_pkg::ST_INDEX_FULL};
                        else if (n_reg >= FL_W'(BUCKET_DEPTH))
                            out_reg <= {73'd0, fbki_pkg::ST_BUCKET_FULL};
                        else begin
                            out_reg <= {73'd0, fbki_pkg::ST_OK};
                            if (total_reg != fbki_pkg::CNT_SAT)
                                total_reg <= total_reg + 1'b1;
                        end
                        ov_reg <= 1'b1;
                        st_reg <= S_IDLE;
                    end else if (n_reg == '0) begin
                        out_reg <= {72'd0, 1'b0, fbki_pkg::ST_NOT_FOUND};
                        ov_reg <= 1'b1;
                        st_reg <= S_IDLE;
                    end else begin
                        st_reg <= S_SCAN;   // read of slot 0 issued
                    end
                end
                S_SCAN: begin
                    hit_reg <= idx_reg[SL_W-1:0];
                    idx_reg <= idx_reg + 1'b1;
                    st_reg <= S_CMP;
                end
                S_CMP: begin
                    if (key_eq) begin
                        if (op_reg == fbki_pkg::OP_UPDATE) begin
                            out_reg <= {req_reg.size, req_reg.offset, 1'b1,
                                        fbki_pkg::ST_OK};
                            st_reg <= S_WB;
                        end else begin
                            out_reg <= {rd_reg.size, rd_reg.offset, 1'b1,
                                        fbki_pkg::ST_OK};
                            ov_reg <= 1'b1;
                            st_reg <= S_IDLE;
                        end
                    end else if (idx_reg >= n_reg) begin
                        out_reg <= {72'd0, 1'b0, fbki_pkg::ST_NOT_FOUND};
                        ov_reg <= 1'b1;
                        st_reg <= S_IDLE;
                    end else begin
                        st_reg <= S_SCAN;
                    end
                end
                S_WB: begin
                    ov_reg <= 1'b1;
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // fill table: cleared after reset, bumped on insert, read on accept
    always_ff @(posedge aclk) begin
        if (clr_reg)
            fill_mem[clr_idx_reg] <= '0;
        else if (ins_ok)
            fill_mem[bk_reg] <= n_reg + 1'b1;
        if (s_tvalid && s_tready)
            n_reg <= fill_mem[in_e.key_high[63 -: BK_W]];
    end
endmodule

>>> hw/rtl/fbki_checker.sv
// Port-level checker for the bucketed key index, bound to the top level.
// Depends on fbki_pkg and the defines header.
`timescale 1ns / 1ps
`include "first_byte_bucketed_key_index_unit_defines.svh"
module fbki_assert_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic [fbki_pkg::IN_BYTES_W-1:0] s_tdata,
    input logic m_tvalid,
    input logic m_tready,
    input logic [fbki_pkg::OUT_BYTES_W-1:0] m_tdata
);
    // one word in flight: no accept while a result waits
    `FBK_ASSERT_IMPL(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready)
    // a stalled result holds
    `FBK_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))
    // found is set only with status OK (a lookup/update hit)
    `FBK_ASSERT_IMPL(a_found, aclk, aresetn, m_tvalid && m_tdata[2],
        m_tdata[1:0] == fbki_pkg::ST_OK)
    // a result never follows directly on the accept
    `FBK_ASSERT_NEXT(a_lat, aclk, aresetn, s_tvalid && s_tready, !m_tvalid)
endmodule

bind first_byte_bucketed_key_index_unit fbki_assert_checker u_fbki_checker (.*);

>>> tb/fbki_checker.sv
// Checker for the bucketed key index: watches request, result and config channels,
// predicts each result from its own copy of the index, compares. Depends on fbki_pkg.
`timescale 1ns / 1ps
module fbki_checker (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    input  logic s_tready,
    input  logic [fbki_pkg::IN_BYTES_W-1:0] s_tdata,
    input  logic m_tvalid,
    input  logic m_tready,
    input  logic [fbki_pkg::OUT_BYTES_W-1:0] m_tdata,
    input  logic cfg_valid,
    input  logic cfg_ready,
    input  logic [fbki_pkg::CNT_W-1:0] cfg_data,
    output int   fail_count,
    output int   pending_results
);
    import fbki_pkg::*;

    typedef struct packed {
        logic [31:0] size;
        logic [39:0] offset;
        logic        found;
        logic [1:0]  status;
    } result_t;

    localparam int DEPTH = BUCKET_DEPTH_DEF;

    entry_t          slots [BUCKET_COUNT_DEF*DEPTH];
    int              fill [BUCKET_COUNT_DEF];
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] limit;
    result_t         result_queue [$];

    assign pending_results = result_queue.size();

    function automatic result_t index_apply(input logic [IN_BYTES_W-1:0] w);
        logic [1:0]  op;
        entry_t      e;
        int          b;
        int          hit;
        result_t     r;
        op = w[1:0];
        e.key_high = w[65:2];
        e.key_mid = w[129:66];
        e.key_low = w[161:130];
        e.offset = w[201:162];
        e.size = w[233:202];
        b = e.key_high[63:56];
        r = '0;
        if (op == OP_INSERT) begin
            if (total >= limit) begin
                r.status = ST_INDEX_FULL;
            end else if (fill[b] >= DEPTH) begin
                r.status = ST_BUCKET_FULL;
            end else begin
                slots[b*DEPTH + fill[b]] = e;
                fill[b]++;
                if (total != CNT_SAT) total++;
                r.status = ST_OK;
            end
        end else begin
            hit = -1;
            for (int i = 0; i < fill[b] && hit < 0; i++)
                if (slots[b*DEPTH+i].key_high == e.key_high &&
                    slots[b*DEPTH+i].key_mid == e.key_mid &&
                    slots[b*DEPTH+i].key_low == e.key_low) hit = b*DEPTH + i;
            if (hit < 0) begin
                r.status = ST_NOT_FOUND;
            end else begin
                if (op == OP_UPDATE) begin
                    slots[hit].offset = e.offset;
                    slots[hit].size = e.size;
                end
                r.status = ST_OK;
                r.found = 1'b1;
                r.offset = slots[hit].offset;
                r.size = slots[hit].size;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t want, got;
        if (!aresetn) begin
            for (int i = 0; i < BUCKET_COUNT_DEF; i++) fill[i] = 0;
            total = '0;
            limit = MAX_ITEMS_RST;
            result_queue.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) limit = cfg_data;
            if (m_tvalid && m_tready) begin
                got = m_tdata[OUT_W-1:0];
                if (result_queue.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = result_queue.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected st=%0d f=%0d off=%h sz=%h",
                                 $time, want.status, want.found, want.offset, want.size);
                        $display("%0t:          actual   st=%0d f=%0d off=%h sz=%h",
                                 $time, got.status, got.found, got.offset, got.size);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) result_queue.push_back(index_apply(s_tdata));
        end
    end
endmodule

>>> tb/tb_first_byte_bucketed_key_index_unit.sv
// Testbench top for the bucketed key index: drives requests, config writes and
// result back-pressure; fbki_checker does prediction. Depends on fbki_pkg, DUT.
`timescale 1ns / 1ps
module tb_first_byte_bucketed_key_index_unit;
    import fbki_pkg::*;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [IN_BYTES_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_BYTES_W-1:0] m_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [CNT_W-1:0] cfg_data;
    int   fail_count;
    int   pending_results;
    int   idle_cycles = 0;
    bit   long_hold;     // receiver holds off for a long stretch

    // pool of keys already offered, so lookups/updates mostly hit
    logic [159:0] key_pool [$];
    byte unsigned hot_buckets [4] = '{8'h00, 8'hFF, 8'h5A, 8'h81};

    first_byte_bucketed_key_index_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    fbki_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog: cycles with no word moving on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: a random stall before each word, plus one long hold
    initial begin
        int wait_n;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                long_hold = 1'b0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            m_tready <= 1'b0;
            repeat (wait_n) @(posedge aclk);
            m_tready <= 1'b1;
            @(posedge aclk iff m_tvalid);
        end
    end

    task automatic send_word(input logic [1:0] op, input logic [159:0] key,
                             input logic [39:0] off, input logic [31:0] sz, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {6'd0, sz, off, key[31:0], key[95:32], key[159:96], op};
        s_tvalid <= 1'b1;
        @(posedge aclk iff s_tready);
    endtask

    // wait for all results, then let any in-flight work settle
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending_results == 0);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] v);
        drain();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk iff cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [159:0] fresh_key(input bit hot);
        logic [159:0] k;
        k = {$urandom, $urandom, $urandom, $urandom, $urandom};
        if (hot) k[159:152] = hot_buckets[$urandom_range(0, 3)];
        return k;
    endfunction

    task automatic random_word(input bit gaps);
        logic [159:0] k;
        logic [1:0]   op;
        int           pick;
        pick = $urandom_range(0, 99);
        if (pick < 40 || key_pool.size() == 0) begin
            op = OP_INSERT;
            k = ($urandom_range(0, 4) == 0 && key_pool.size() > 0) ?
                key_pool[$urandom_range(0, key_pool.size()-1)] : fresh_key($urandom_range(0, 2) == 0);
            key_pool.push_back(k);
        end else begin
            op = (pick < 70) ? OP_LOOKUP : (pick < 95) ? OP_UPDATE : 2'd3;
            k = ($urandom_range(0, 4) == 0) ? fresh_key(1'b1) :
                key_pool[$urandom_range(0, key_pool.size()-1)];
        end
        send_word(op, k, 40'({$urandom, $urandom}), $urandom, gaps);
    endtask

    initial begin
        logic [159:0] kmax;
        logic [159:0] kz;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        long_hold = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, each operation, duplicates, misses, op 3
        kmax = '1;
        kz = '0;
        send_word(OP_LOOKUP, kz, '0, '0, 1'b0);            // miss on empty bucket
        send_word(OP_INSERT, kz, '0, '0, 1'b0);
        send_word(OP_INSERT, kmax, '1, '1, 1'b0);
        send_word(OP_INSERT, kmax, 40'h12345, 32'h9, 1'b0); // duplicate key
        send_word(OP_LOOKUP, kmax, '0, '0, 1'b0);          // sees earliest
        send_word(OP_UPDATE, kmax, 40'hABCDE, 32'h77, 1'b0);
        send_word(2'd3, kmax, '0, '0, 1'b0);               // unused op acts as lookup
        send_word(OP_UPDATE, {8'hFF, 152'h1}, '1, '1, 1'b0); // update miss
        send_word(OP_LOOKUP, kz, '1, '1, 1'b0);
        // fill bucket 0x5A past its depth
        for (int i = 0; i < 17; i++) send_word(OP_INSERT, {8'h5A, 152'(i)}, 40'(i), 32'(i), 1'b1);
        key_pool.push_back(kmax);
        key_pool.push_back(kz);

        // index full paths: limit 0, small limit, then back to max
        write_limit(13'd0);
        send_word(OP_INSERT, fresh_key(1'b0), '1, '1, 1'b0);
        write_limit(13'd25);
        for (int i = 0; i < 10; i++) random_word(1'b1);
        write_limit(13'h1FFF);

        // long hold on results while requests keep coming
        long_hold = 1'b1;
        for (int i = 0; i < 30; i++) random_word(1'b0);
        drain();   // sender pause until every result is back

        for (int n = 0; n < 1750; n++) begin
            if (n == 600) write_limit(13'd400);
            if (n == 1100) write_limit(13'd4096);
            random_word((n / 200) % 3 != 0);
        end
        drain();

        if (fail_count == 0 && pending_results == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
